// ===== rtl/core/tps_pkg.sv =====
// Shared types and constants of the triangle plane splitter.
package tps_pkg;

  localparam int CoordBits = 32;
  localparam int NumLanes  = 6;
  localparam int NumCoords = 9;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  localparam logic CFG_AXIS  = 1'b0;
  localparam logic CFG_PLANE = 1'b1;

  typedef enum logic [1:0] {
    KIND_POS   = 2'd0,
    KIND_NEG   = 2'd1,
    KIND_SPLIT = 2'd2,
    KIND_DROP  = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic       lone_side;
    logic [1:0] lone;
    logic [1:0] oth0;
    logic [1:0] oth1;
    logic [1:0] axis;
  } ctrl_t;

endpackage

// ===== rtl/core/tps_classify.sv =====
// First stage: signed distance of each vertex to the plane.
module tps_classify #(
  parameter int W = tps_pkg::CoordBits
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    en_i,
  input  logic                                    valid_i,
  input  logic [tps_pkg::NumCoords-1:0][W-1:0]    vert_i,
  input  logic [W-1:0]                            plane_i,
  input  logic [1:0]                              axis_i,
  output logic                                    valid_o,
  output logic [tps_pkg::NumCoords-1:0][W-1:0]    vert_o,
  output logic [2:0][W:0]                         dist_o,
  output logic [W-1:0]                            plane_o,
  output logic [1:0]                              axis_o
);

  logic                                 valid_q;
  logic [tps_pkg::NumCoords-1:0][W-1:0] vert_q;
  logic [2:0][W:0]                      dist_q, dist_d;
  logic [W-1:0]                         plane_q;
  logic [1:0]                           axis_q, axis_d;
  logic [2:0][W-1:0]                    sel;

  // Selector three folds onto z.
  assign axis_d = (axis_i == tps_pkg::AXIS_X || axis_i == tps_pkg::AXIS_Y) ?
                  axis_i : tps_pkg::AXIS_Z;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      unique case (axis_d)
        tps_pkg::AXIS_X: sel[i] = vert_i[i*3];
        tps_pkg::AXIS_Y: sel[i] = vert_i[i*3+1];
        default:         sel[i] = vert_i[i*3+2];
      endcase
      dist_d[i] = {sel[i][W-1], sel[i]} - {plane_i[W-1], plane_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      vert_q  <= vert_i;
      dist_q  <= dist_d;
      plane_q <= plane_i;
      axis_q  <= axis_d;
    end
  end

  assign valid_o = valid_q;
  assign vert_o  = vert_q;
  assign dist_o  = dist_q;
  assign plane_o = plane_q;
  assign axis_o  = axis_q;

endmodule

// ===== rtl/core/tps_setup.sv =====
// Second stage: sign classes, case decode and divider operands per crossing edge.
module tps_setup #(
  parameter int W = tps_pkg::CoordBits
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    en_i,
  input  logic                                    valid_i,
  input  logic [tps_pkg::NumCoords-1:0][W-1:0]    vert_i,
  input  logic [2:0][W:0]                         dist_i,
  input  logic [W-1:0]                            plane_i,
  input  logic [1:0]                              axis_i,
  output logic                                    valid_o,
  output tps_pkg::ctrl_t                          ctrl_o,
  output logic [tps_pkg::NumCoords-1:0][W-1:0]    vert_o,
  output logic [W-1:0]                            plane_o,
  output logic [tps_pkg::NumLanes-1:0][W-1:0]     lane_a_o,
  output logic [tps_pkg::NumLanes-1:0][W-1:0]     lane_b_o,
  output logic [tps_pkg::NumLanes-1:0][W:0]       lane_d_o,
  output logic [tps_pkg::NumLanes-1:0]            lane_neg_o,
  output logic [tps_pkg::NumLanes-1:0][W-1:0]     lane_base_o
);

  localparam int NL = tps_pkg::NumLanes;

  logic [2:0]       pos, neg, xing;
  logic [2:0][W-1:0] dmag;
  logic [1:0]       npos, nneg, ncross;
  logic [1:0]       edge0, edge1, ei, ej, lone;
  logic [3:0]       idx_i, idx_j;
  logic [W:0]       delta;
  logic [W-1:0]     vi, vj;
  tps_pkg::ctrl_t   ctrl_d;
  logic [NL-1:0][W-1:0] a_d, b_d, base_d;
  logic [NL-1:0][W:0]   d_d;
  logic [NL-1:0]        neg_d;

  logic                                 valid_q;
  tps_pkg::ctrl_t                       ctrl_q;
  logic [tps_pkg::NumCoords-1:0][W-1:0] vert_q;
  logic [W-1:0]                         plane_q;
  logic [NL-1:0][W-1:0]                 a_q, b_q, base_q;
  logic [NL-1:0][W:0]                   d_q;
  logic [NL-1:0]                        neg_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      neg[i]  = dist_i[i][W];
      pos[i]  = !dist_i[i][W] && (dist_i[i] != '0);
      dmag[i] = dist_i[i][W] ? W'(~dist_i[i] + 1'b1) : dist_i[i][W-1:0];
    end
    for (int e = 0; e < 3; e++) begin
      xing[e] = (pos[e] && neg[(e+1)%3]) || (neg[e] && pos[(e+1)%3]);
    end
    npos   = 2'($countones(pos));
    nneg   = 2'($countones(neg));
    ncross = 2'($countones(xing));
    edge0  = xing[0] ? 2'd0 : (xing[1] ? 2'd1 : 2'd2);
    edge1  = xing[2] ? 2'd2 : (xing[1] ? 2'd1 : 2'd0);

    lone = 2'd0;
    for (int i = 0; i < 3; i++) begin
      if ((npos == 2'd1) ? pos[i] : neg[i]) lone = 2'(i);
    end

    if (nneg == 2'd0) begin
      ctrl_d.kind = tps_pkg::KIND_POS;
    end else if (npos == 2'd0) begin
      ctrl_d.kind = tps_pkg::KIND_NEG;
    end else if (ncross == 2'd2) begin
      ctrl_d.kind = tps_pkg::KIND_SPLIT;
    end else begin
      ctrl_d.kind = tps_pkg::KIND_DROP;
    end
    ctrl_d.lone_side = (npos != 2'd1);
    ctrl_d.lone      = lone;
    ctrl_d.oth0      = (lone == 2'd0) ? 2'd1 : 2'd0;
    ctrl_d.oth1      = (lone == 2'd2) ? 2'd1 : 2'd2;
    ctrl_d.axis      = axis_i;

    // Lanes 0..2 hold the first crossing point, lanes 3..5 the second.
    for (int k = 0; k < 2; k++) begin
      ei = (k == 0) ? edge0 : edge1;
      ej = (ei == 2'd2) ? 2'd0 : ei + 2'd1;
      for (int c = 0; c < 3; c++) begin
        idx_i = 4'(ei) * 4'd3 + 4'(c);
        idx_j = 4'(ej) * 4'd3 + 4'(c);
        vi    = vert_i[idx_i];
        vj    = vert_i[idx_j];
        delta = {vj[W-1], vj} - {vi[W-1], vi};
        a_d[k*3+c]    = delta[W] ? W'(~delta + 1'b1) : delta[W-1:0];
        neg_d[k*3+c]  = delta[W];
        b_d[k*3+c]    = dmag[ei];
        d_d[k*3+c]    = {1'b0, dmag[ei]} + {1'b0, dmag[ej]};
        base_d[k*3+c] = vi;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ctrl_q  <= ctrl_d;
      vert_q  <= vert_i;
      plane_q <= plane_i;
      a_q     <= a_d;
      b_q     <= b_d;
      d_q     <= d_d;
      neg_q   <= neg_d;
      base_q  <= base_d;
    end
  end

  assign valid_o     = valid_q;
  assign ctrl_o      = ctrl_q;
  assign vert_o      = vert_q;
  assign plane_o     = plane_q;
  assign lane_a_o    = a_q;
  assign lane_b_o    = b_q;
  assign lane_d_o    = d_q;
  assign lane_neg_o  = neg_q;
  assign lane_base_o = base_q;

endmodule

// ===== rtl/core/tps_muldiv.sv =====
// Pipelined floor(a*b/d) for six lanes, one bit of a per stage, with a carried payload.
module tps_muldiv #(
  parameter int W      = tps_pkg::CoordBits,
  parameter int SIDE_W = 1
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                valid_i,
  input  logic [tps_pkg::NumLanes-1:0][W-1:0] a_i,
  input  logic [tps_pkg::NumLanes-1:0][W-1:0] b_i,
  input  logic [tps_pkg::NumLanes-1:0][W:0]   d_i,
  input  logic [SIDE_W-1:0]                   side_i,
  output logic                                valid_o,
  output logic [tps_pkg::NumLanes-1:0][W-1:0] q_o,
  output logic [SIDE_W-1:0]                   side_o
);

  localparam int NL = tps_pkg::NumLanes;

  // Invariant per stage: q*d + r equals the processed prefix of a times b, r below d.
  logic                 v_q    [W];
  logic [NL-1:0][W:0]   r_q    [W];
  logic [NL-1:0][W-1:0] qt_q   [W];
  logic [NL-1:0][W-1:0] a_q    [W];
  logic [NL-1:0][W-1:0] b_q    [W];
  logic [NL-1:0][W:0]   d_q    [W];
  logic [SIDE_W-1:0]    side_q [W];

  for (genvar s = 0; s < W; s++) begin : g_stage
    logic                 v_in;
    logic [NL-1:0][W:0]   r_in, r_d, d_in;
    logic [NL-1:0][W-1:0] q_in, q_d, a_in, b_in;
    logic [SIDE_W-1:0]    side_in;

    if (s == 0) begin : g_first
      assign v_in    = valid_i;
      assign r_in    = '0;
      assign q_in    = '0;
      assign a_in    = a_i;
      assign b_in    = b_i;
      assign d_in    = d_i;
      assign side_in = side_i;
    end else begin : g_next
      assign v_in    = v_q[s-1];
      assign r_in    = r_q[s-1];
      assign q_in    = qt_q[s-1];
      assign a_in    = a_q[s-1];
      assign b_in    = b_q[s-1];
      assign d_in    = d_q[s-1];
      assign side_in = side_q[s-1];
    end

    always_comb begin
      logic [W+2:0] t, t1, t2, d1, d2;
      logic [1:0]   f;
      for (int l = 0; l < NL; l++) begin
        d1 = (W+3)'(d_in[l]);
        d2 = {1'b0, d_in[l], 1'b0};
        t  = {1'b0, r_in[l], 1'b0} + (a_in[l][W-1] ? (W+3)'(b_in[l]) : '0);
        t1 = t - d1;
        t2 = t - d2;
        if (t >= d2) begin
          r_d[l] = t2[W:0];
          f      = 2'd2;
        end else if (t >= d1) begin
          r_d[l] = t1[W:0];
          f      = 2'd1;
        end else begin
          r_d[l] = t[W:0];
          f      = 2'd0;
        end
        q_d[l] = {q_in[l][W-2:0], 1'b0} + W'(f);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else if (en_i) begin
        v_q[s] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[s]    <= r_d;
        qt_q[s]   <= q_d;
        b_q[s]    <= b_in;
        d_q[s]    <= d_in;
        side_q[s] <= side_in;
        for (int l = 0; l < NL; l++) begin
          a_q[s][l] <= {a_in[l][W-2:0], 1'b0};
        end
      end
    end
  end

  assign valid_o = v_q[W-1];
  assign q_o     = qt_q[W-1];
  assign side_o  = side_q[W-1];

endmodule

// ===== rtl/core/tps_emit.sv =====
// Output stage: finishes crossing points and sends up to three triangles per input.
module tps_emit #(
  parameter int W = tps_pkg::CoordBits
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    valid_i,
  output logic                                    ready_o,
  input  tps_pkg::ctrl_t                          ctrl_i,
  input  logic [tps_pkg::NumCoords-1:0][W-1:0]    vert_i,
  input  logic [W-1:0]                            plane_i,
  input  logic [tps_pkg::NumLanes-1:0]            neg_i,
  input  logic [tps_pkg::NumLanes-1:0][W-1:0]     base_i,
  input  logic [tps_pkg::NumLanes-1:0][W-1:0]     q_i,
  output logic                                    m_valid_o,
  input  logic                                    m_ready_i,
  output logic                                    side_o,
  output logic [tps_pkg::NumCoords-1:0][W-1:0]    tri_o,
  output logic                                    last_o
);

  localparam int NL = tps_pkg::NumLanes;

  logic                                 busy_q, busy_d;
  logic [1:0]                           piece_q, piece_d;
  tps_pkg::ctrl_t                       ctrl_q;
  logic [tps_pkg::NumCoords-1:0][W-1:0] vert_q;
  logic [NL-1:0][W-1:0]                 x_q, x_d;
  logic                                 load, fire, done;
  logic [2:0][W-1:0]                    vl, vo0, vo1, x0, x1;

  always_comb begin
    for (int l = 0; l < NL; l++) begin
      if (2'(l % 3) == ctrl_i.axis) begin
        x_d[l] = plane_i;
      end else begin
        x_d[l] = neg_i[l] ? base_i[l] - q_i[l] : base_i[l] + q_i[l];
      end
    end
  end

  assign fire    = busy_q && m_ready_i;
  assign done    = fire && last_o;
  assign ready_o = !busy_q || done;
  // Dropped triangles are consumed here and never reach the output.
  assign load    = valid_i && ready_o && (ctrl_i.kind != tps_pkg::KIND_DROP);

  always_comb begin
    busy_d  = busy_q;
    piece_d = piece_q;
    if (load) begin
      busy_d  = 1'b1;
      piece_d = 2'd0;
    end else if (done) begin
      busy_d  = 1'b0;
    end else if (fire) begin
      piece_d = piece_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      piece_q <= 2'd0;
    end else begin
      busy_q  <= busy_d;
      piece_q <= piece_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      ctrl_q <= ctrl_i;
      vert_q <= vert_i;
      x_q    <= x_d;
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      vl[c]  = vert_q[4'(ctrl_q.lone) * 4'd3 + 4'(c)];
      vo0[c] = vert_q[4'(ctrl_q.oth0) * 4'd3 + 4'(c)];
      vo1[c] = vert_q[4'(ctrl_q.oth1) * 4'd3 + 4'(c)];
      x0[c]  = x_q[c];
      x1[c]  = x_q[c+3];
    end
    if (ctrl_q.kind != tps_pkg::KIND_SPLIT) begin
      side_o = (ctrl_q.kind == tps_pkg::KIND_NEG);
      tri_o  = vert_q;
      last_o = 1'b1;
    end else begin
      case (piece_q)
        2'd0: begin
          side_o = ctrl_q.lone_side;
          tri_o  = {x1, x0, vl};
          last_o = 1'b0;
        end
        2'd1: begin
          side_o = !ctrl_q.lone_side;
          tri_o  = {x0, vo1, vo0};
          last_o = 1'b0;
        end
        default: begin
          side_o = !ctrl_q.lone_side;
          tri_o  = {x0, x1, vo1};
          last_o = 1'b1;
        end
      endcase
    end
  end

  assign m_valid_o = busy_q;

endmodule

// ===== rtl/core/triangle_plane_splitter_core.sv =====
// Top level of the triangle plane splitter.
//
//  channel | direction | contents
//  s_axis  | in        | one triangle: nine coordinates
//  m_axis  | out       | one result triangle, side in tuser, tlast on the final piece
//  cfg     | in        | register writes: split axis, plane position
//
// A triangle passes through two setup stages, one divider stage per coordinate bit
// and the output register, the first stage being loaded by the transaction itself.
// The single result channel sets throughput: one transaction per cycle for a triangle
// on one side while the output is ready, three output transfers for a split triangle.
// Reset clears all valid bits and both registers; the pipeline holds as a whole
// while its last stage waits on the output, so nothing is lost or repeated.
module triangle_plane_splitter_core #(
  parameter int COORD_BITS = tps_pkg::CoordBits
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, zero fill
  input  logic [((9*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // p_x, p_y, p_z, q_x, q_y, q_z, r_x, r_y, r_z, zero fill
  output logic [((9*COORD_BITS+7)/8)*8-1:0] m_axis_tdata,
  // side
  output logic                  m_axis_tuser,
  output logic                  m_axis_tlast,
  input  logic                  cfg_we_i,
  input  logic                  cfg_idx_i,
  input  logic [COORD_BITS-1:0] cfg_wdata_i
);

  localparam int W     = COORD_BITS;
  localparam int NL    = tps_pkg::NumLanes;
  localparam int NC    = tps_pkg::NumCoords;
  localparam int DataW = ((9*W+7)/8)*8;
  localparam int CtrlW = $bits(tps_pkg::ctrl_t);
  localparam int SideW = CtrlW + (NC + 1 + NL) * W + NL;

  logic [1:0]   axis_q;
  logic [W-1:0] plane_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      axis_q  <= 2'd0;
      plane_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tps_pkg::CFG_AXIS:  axis_q  <= cfg_wdata_i[1:0];
        default:            plane_q <= cfg_wdata_i;
      endcase
    end
  end

  logic                  adv;
  logic [NC-1:0][W-1:0]  in_vert;

  logic                  a_valid;
  logic [NC-1:0][W-1:0]  a_vert;
  logic [2:0][W:0]       a_dist;
  logic [W-1:0]          a_plane;
  logic [1:0]            a_axis;

  logic                  b_valid;
  tps_pkg::ctrl_t        b_ctrl;
  logic [NC-1:0][W-1:0]  b_vert;
  logic [W-1:0]          b_plane;
  logic [NL-1:0][W-1:0]  b_a, b_b, b_base;
  logic [NL-1:0][W:0]    b_d;
  logic [NL-1:0]         b_neg;

  logic                  m_valid;
  logic [NL-1:0][W-1:0]  m_q, m_base;
  logic [SideW-1:0]      m_side;
  tps_pkg::ctrl_t        m_ctrl;
  logic [NC-1:0][W-1:0]  m_vert;
  logic [W-1:0]          m_plane;
  logic [NL-1:0]         m_neg;

  logic                  emit_ready;
  logic [NC-1:0][W-1:0]  out_tri;

  assign in_vert       = s_axis_tdata[NC*W-1:0];
  assign adv           = !m_valid || emit_ready;
  assign s_axis_tready = adv;

  tps_classify #(.W(W)) u_classify (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (s_axis_tvalid),
    .vert_i  (in_vert),
    .plane_i (plane_q),
    .axis_i  (axis_q),
    .valid_o (a_valid),
    .vert_o  (a_vert),
    .dist_o  (a_dist),
    .plane_o (a_plane),
    .axis_o  (a_axis)
  );

  tps_setup #(.W(W)) u_setup (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (adv),
    .valid_i     (a_valid),
    .vert_i      (a_vert),
    .dist_i      (a_dist),
    .plane_i     (a_plane),
    .axis_i      (a_axis),
    .valid_o     (b_valid),
    .ctrl_o      (b_ctrl),
    .vert_o      (b_vert),
    .plane_o     (b_plane),
    .lane_a_o    (b_a),
    .lane_b_o    (b_b),
    .lane_d_o    (b_d),
    .lane_neg_o  (b_neg),
    .lane_base_o (b_base)
  );

  tps_muldiv #(.W(W), .SIDE_W(SideW)) u_muldiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (b_valid),
    .a_i     (b_a),
    .b_i     (b_b),
    .d_i     (b_d),
    .side_i  ({b_ctrl, b_plane, b_neg, b_base, b_vert}),
    .valid_o (m_valid),
    .q_o     (m_q),
    .side_o  (m_side)
  );

  assign {m_ctrl, m_plane, m_neg, m_base, m_vert} = m_side;

  tps_emit #(.W(W)) u_emit (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (m_valid),
    .ready_o   (emit_ready),
    .ctrl_i    (m_ctrl),
    .vert_i    (m_vert),
    .plane_i   (m_plane),
    .neg_i     (m_neg),
    .base_i    (m_base),
    .q_i       (m_q),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .side_o    (m_axis_tuser),
    .tri_o     (out_tri),
    .last_o    (m_axis_tlast)
  );

  assign m_axis_tdata = DataW'(out_tri);

  // A held pipeline keeps its oldest item.
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid && !adv) |=> m_valid)
    else $error("divider output lost during stall");

  // A split triangle always has two nonzero distances on each crossing edge.
  a_split_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (b_valid && b_ctrl.kind == tps_pkg::KIND_SPLIT) |-> (b_d[0] != '0 && b_d[3] != '0))
    else $error("split triangle with zero divisor");

  // More pieces of the same input follow a non-final piece.
  a_pieces_follow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=> m_axis_tvalid)
    else $error("result sequence cut short");

endmodule

// ===== tb/triangle_plane_splitter_core_tb.sv =====
// Self-checking testbench of the triangle plane splitter core.
module triangle_plane_splitter_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CB = tps_pkg::CoordBits;
  localparam int DW = ((9*CB+7)/8)*8;
  localparam int LATENCY = CB + 3;

  typedef logic signed [CB-1:0] coord_t;

  typedef struct {
    logic   side;
    coord_t v [9];
    logic   last;
  } piece_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [DW-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [DW-1:0] m_axis_tdata;
  logic m_axis_tuser;
  logic m_axis_tlast;
  logic cfg_we_i = 1'b0;
  logic cfg_idx_i = tps_pkg::CFG_AXIS;
  logic [CB-1:0] cfg_wdata_i = '0;

  triangle_plane_splitter_core dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Configuration mirror.
  logic [1:0] axis_sel = tps_pkg::AXIS_X;
  coord_t plane_pos = '0;

  logic [DW-1:0] triangle_queue [$];
  piece_t expected_pieces [$];
  int errors = 0;
  int send_idle_pct = 8;
  int recv_idle_pct = 64;
  int hold_cycles = 0;
  // Set when the input transaction offered at the last rising edge was taken.
  logic in_taken = 1'b0;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    errors++;
  endtask

  task automatic queue_triangle(logic [DW-1:0] t);
    triangle_queue = {triangle_queue, t};
  endtask

  // Crossing coordinate vi + trunc((vj-vi)*di/(di-dj)) held exactly.
  function automatic coord_t crossing_coord(coord_t vi, coord_t vj,
                                            logic signed [CB:0] di,
                                            logic signed [CB:0] dj);
    logic signed [127:0] num;
    logic signed [127:0] den;
    logic signed [127:0] q;
    num = (128'(signed'(vj)) - 128'(signed'(vi))) * 128'(signed'(di));
    den = 128'(signed'(di)) - 128'(signed'(dj));
    q = num / den;
    return coord_t'(128'(signed'(vi)) + q);
  endfunction

  task automatic push_piece(logic side, coord_t p [3], coord_t q [3], coord_t r [3],
                            logic last);
    piece_t pc;
    for (int c = 0; c < 3; c++) begin
      pc.v[c] = p[c];
      pc.v[3+c] = q[c];
      pc.v[6+c] = r[c];
    end
    pc.side = side;
    pc.last = last;
    expected_pieces = {expected_pieces, pc};
  endtask

  task automatic split_triangle(logic [DW-1:0] data);
    coord_t v [3][3];
    coord_t x [2][3];
    logic signed [CB:0] d [3];
    int s [3];
    int ax, npos, nneg, nx, lone, o0, o1, lone_side, j;
    logic ls;
    npos = 0;
    nneg = 0;
    nx = 0;
    ax = (axis_sel >= 2) ? 2 : int'(axis_sel);
    for (int i = 0; i < 3; i++) begin
      for (int c = 0; c < 3; c++) v[i][c] = data[(i*3+c)*CB +: CB];
      d[i] = (CB+1)'(v[i][ax]) - (CB+1)'(plane_pos);
      s[i] = (d[i] > 0) ? 1 : ((d[i] < 0) ? -1 : 0);
      if (s[i] > 0) npos++;
      if (s[i] < 0) nneg++;
    end
    if (nneg == 0 || npos == 0) begin
      push_piece(nneg != 0, v[0], v[1], v[2], 1'b1);
      return;
    end
    for (int i = 0; i < 3; i++) begin
      j = (i == 2) ? 0 : i + 1;
      if (s[i] * s[j] < 0) begin
        for (int c = 0; c < 3; c++) x[nx][c] = crossing_coord(v[i][c], v[j][c], d[i], d[j]);
        x[nx][ax] = plane_pos;
        nx++;
      end
    end
    // A vertex on the plane leaves a single crossing point: nothing comes out.
    if (nx != 2) return;
    lone_side = (npos == 1) ? 1 : -1;
    lone = 0;
    for (int i = 0; i < 3; i++) if (s[i] == lone_side) lone = i;
    o0 = (lone == 0) ? 1 : 0;
    o1 = (lone == 2) ? 1 : 2;
    ls = (lone_side > 0) ? 1'b0 : 1'b1;
    push_piece(ls, v[lone], x[0], x[1], 1'b0);
    push_piece(!ls, v[o0], v[o1], x[0], 1'b0);
    push_piece(!ls, v[o1], x[1], x[0], 1'b1);
  endtask

  // Driver.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!s_axis_tvalid || in_taken) begin
        if (triangle_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          s_axis_tdata <= triangle_queue.pop_front();
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      m_axis_tready <= (hold_cycles == 0) && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(negedge clk_i) if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;

  // Monitor: predicts on input transactions, checks on output transactions.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      in_taken <= s_axis_tvalid && s_axis_tready;
      if (s_axis_tvalid && s_axis_tready) split_triangle(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_pieces.size() == 0) begin
          report_mismatch("result triangle with nothing expected");
        end else begin
          piece_t e;
          e = expected_pieces.pop_front();
          if (m_axis_tuser !== e.side)
            report_mismatch($sformatf("side %b, expected %b", m_axis_tuser, e.side));
          if (m_axis_tlast !== e.last)
            report_mismatch($sformatf("last %b, expected %b", m_axis_tlast, e.last));
          for (int k = 0; k < 9; k++)
            if (m_axis_tdata[k*CB +: CB] !== e.v[k])
              report_mismatch($sformatf("coordinate %0d is %h, expected %h", k,
                                        m_axis_tdata[k*CB +: CB], e.v[k]));
          if ((m_axis_tdata >> (9*CB)) !== '0) report_mismatch("fill bits not zero");
        end
      end
    end
  end

  task automatic write_reg(logic idx, logic [CB-1:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == tps_pkg::CFG_AXIS) axis_sel = val[1:0];
    else plane_pos = val;
  endtask

  task automatic wait_drained();
    while (triangle_queue.size() > 0 || s_axis_tvalid || expected_pieces.size() > 0)
      @(posedge clk_i);
    repeat (LATENCY + 5) @(posedge clk_i);
  endtask

  function automatic coord_t near_plane();
    case ($urandom_range(5))
      0: return plane_pos;
      1, 2: return plane_pos + coord_t'($urandom_range(1 << 20));
      3, 4: return plane_pos - coord_t'($urandom_range(1 << 20));
      default: return coord_t'($urandom);
    endcase
  endfunction

  // A triangle whose axis coordinates mostly straddle the plane.
  function automatic logic [DW-1:0] rand_triangle();
    logic [DW-1:0] t;
    int ax;
    t = '0;
    ax = (axis_sel >= 2) ? 2 : int'(axis_sel);
    for (int k = 0; k < 9; k++) begin
      if ($urandom_range(3) == 0) t[k*CB +: CB] = coord_t'($urandom);
      else t[k*CB +: CB] = coord_t'($urandom_range(1 << 22)) - coord_t'(1 << 21);
      if (k % 3 == ax && $urandom_range(9) != 0) t[k*CB +: CB] = near_plane();
    end
    return t;
  endfunction

  function automatic logic [DW-1:0] make_triangle(coord_t a, coord_t b, coord_t c,
                                                  coord_t fill);
    logic [DW-1:0] t;
    t = '0;
    for (int k = 0; k < 9; k++) t[k*CB +: CB] = fill ^ coord_t'(k);
    t[0*CB +: CB] = a;
    t[3*CB +: CB] = b;
    t[6*CB +: CB] = c;
    return t;
  endfunction

  localparam coord_t CMAX = {1'b0, {(CB-1){1'b1}}};
  localparam coord_t CMIN = {1'b1, {(CB-1){1'b0}}};

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed triangles on the reset plane x = 0.
    queue_triangle(make_triangle(1, 2, 3, 5));
    queue_triangle(make_triangle(-1, -2, -3, -5));
    queue_triangle(make_triangle(0, 0, 0, 7));
    queue_triangle(make_triangle(0, -4, -4, 7));
    queue_triangle(make_triangle(5, -3, -7, 9));
    queue_triangle(make_triangle(-5, 3, 7, 9));
    queue_triangle(make_triangle(-5, 3, -7, 11));
    queue_triangle(make_triangle(5, -3, 7, 11));
    queue_triangle(make_triangle(0, 3, -7, 13));
    queue_triangle(make_triangle(CMAX, CMIN, CMAX, CMIN));
    queue_triangle(make_triangle(CMIN, CMAX, 1, CMAX));
    queue_triangle({DW{1'b1}} >> (DW - 9*CB));
    queue_triangle('0);
    wait_drained();

    // Extremes of both registers, selector three included.
    write_reg(tps_pkg::CFG_AXIS, CB'(tps_pkg::AXIS_Z));
    write_reg(tps_pkg::CFG_PLANE, CMAX);
    queue_triangle(make_triangle(0, 0, 0, CMAX));
    queue_triangle(make_triangle(0, 0, 0, CMIN));
    wait_drained();
    write_reg(tps_pkg::CFG_PLANE, CMIN);
    queue_triangle(make_triangle(0, 0, 0, CMAX));
    queue_triangle(make_triangle(0, 0, 0, CMIN));
    wait_drained();
    write_reg(tps_pkg::CFG_AXIS, CB'(2'd3));
    write_reg(tps_pkg::CFG_PLANE, 0);
    queue_triangle(make_triangle(0, 0, 0, 32'h0001_0000));
    queue_triangle(make_triangle(0, 0, 0, 32'hFFFF_0000));
    wait_drained();

    // Random phases with varied idling and settings.
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(tps_pkg::CFG_AXIS, CB'($urandom_range(3)));
      write_reg(tps_pkg::CFG_PLANE, (ph == 5) ? CMIN : coord_t'($urandom_range(1 << 24)) -
                coord_t'(1 << 23));
      send_idle_pct = (ph < 2) ? 8 : (ph < 4) ? 64 : 0;
      recv_idle_pct = (ph < 2) ? 64 : (ph < 4) ? 8 : 0;
      for (int n = 0; n < 25; n++) queue_triangle(rand_triangle());
      if (ph == 4) hold_cycles = 200;
      wait_drained();
    end

    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("DONE: errors detected");
    $finish;
  end
endmodule

// ===== triangle_plane_splitter_core.f =====
rtl/core/tps_pkg.sv
rtl/core/tps_classify.sv
rtl/core/tps_setup.sv
rtl/core/tps_muldiv.sv
rtl/core/tps_emit.sv
rtl/core/triangle_plane_splitter_core.sv
tb/triangle_plane_splitter_core_tb.sv
